[rtl/msid_pkg.sv]
package msid_pkg;

	localparam int MAX_LEVELS  = 6;
	localparam int MAX_STREAMS = 6;
	localparam int INDEX_WIDTH = 32;

	localparam int CNT_W   = 3;
	localparam int LVL_W   = $clog2(MAX_LEVELS);
	localparam int STR_W   = $clog2(MAX_STREAMS);
	localparam int PIECE_W = 6;
	localparam int MAX_PIECE = MAX_STREAMS + MAX_LEVELS * (MAX_STREAMS + 1);

	localparam logic [1:0] FUNC_START   = 2'd0;
	localparam logic [1:0] FUNC_REQUEST = 2'd1;
	localparam logic [1:0] FUNC_WORD    = 2'd2;

	localparam logic [1:0] CFG_LEVEL_COUNT  = 2'd0;
	localparam logic [1:0] CFG_STREAM_COUNT = 2'd1;
	localparam logic [1:0] CFG_ENCODED_MODE = 2'd2;

	typedef logic [INDEX_WIDTH-1:0] index_t;
	typedef logic [31:0] count_t;

	typedef struct packed {
		logic             hit;
		logic [LVL_W-1:0] level;
	} level_sel_t;

	typedef struct packed {
		logic             in_range;
		logic             is_jump;
		logic             is_len;
		logic [LVL_W-1:0] level;
		logic [STR_W-1:0] lane;
	} piece_slot_t;

endpackage

[rtl/multilevel_stride_index_decoder.sv]
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: word[31:0]; tuser: func[1:0]
// m_*       out  m_tvalid/m_tready  tdata: index_0..5, words_needed; tuser: tuple_valid, need_words
// cfg_*     in   cfg_we             cfg_index: register; cfg_data: value
//
// One word per cycle while no held result stalls it; a result word passes the input register,
// then level priority and six index adders, and is stored in the result register.
// Reset clears counts, indices and both valid flags; strides, jumps and saved lengths hold junk.
// A held result stalls only words that produce one; start and stray words still drain.
module multilevel_stride_index_decoder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // word[31:0]
	input  logic [1:0]   s_tuser,   // func[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [199:0] m_tdata,   // index_0..index_5 [191:0], words_needed [197:192], pad
	output logic [1:0]   m_tuser,   // tuple_valid [0], need_words [1]
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [2:0]   cfg_data
);

	localparam int NL = msid_pkg::MAX_LEVELS;
	localparam int NS = msid_pkg::MAX_STREAMS;
	localparam int PW = msid_pkg::PIECE_W;

	logic [msid_pkg::CNT_W-1:0] lc_q, sc_q;
	logic                       enc_q;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [31:0] word_s1;

	msid_pkg::index_t idx_q    [NS];
	msid_pkg::index_t jump_q   [NS];
	msid_pkg::index_t stride_q [NL][NS];
	msid_pkg::count_t [NL-1:0] rem_q;
	msid_pkg::count_t          saved_q [NL];
	logic [PW-1:0]             cnt_q;
	logic                      loading_q;

	msid_pkg::index_t idx_nx [NS];
	msid_pkg::count_t rem_nx [NL];
	msid_pkg::index_t sum    [NS];

	msid_pkg::level_sel_t  sel;
	msid_pkg::piece_slot_t slot;

	logic [PW-1:0] total;
	logic [PW:0]   pos_inc;
	logic          is_start, is_req, is_word;
	logic          step, load_begin, req_wait, word_take, finish, store;
	logic          has_result, adv;
	logic          tuple_o, need_o;
	logic [PW-1:0] owed;
	logic [199:0]  data_o;

	function automatic logic [msid_pkg::CNT_W-1:0] clamp_count(
		input logic [2:0] v, input int maxv);
		logic [msid_pkg::CNT_W-1:0] res;
		begin
			if (v == 3'd0)
				res = msid_pkg::CNT_W'(1);
			else if (32'(v) > maxv)
				res = msid_pkg::CNT_W'(maxv);
			else
				res = v;
			return res;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q  <= msid_pkg::CNT_W'(1);
			sc_q  <= msid_pkg::CNT_W'(1);
			enc_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				msid_pkg::CFG_LEVEL_COUNT:  lc_q  <= clamp_count(cfg_data, NL);
				msid_pkg::CFG_STREAM_COUNT: sc_q  <= clamp_count(cfg_data, NS);
				msid_pkg::CFG_ENCODED_MODE: enc_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	msid_level_select u_level_select (
		.remaining   (rem_q),
		.level_count (lc_q),
		.sel         (sel)
	);

	msid_piece_decode u_piece_decode (
		.pos          (cnt_q),
		.total        (total),
		.stream_count (sc_q),
		.encoded_mode (enc_q),
		.slot         (slot)
	);

	always_comb begin
		if (enc_q)
			total = PW'({3'b000, sc_q} + 6'({3'b000, lc_q} * ({3'b000, sc_q} + 6'd1)));
		else
			total = PW'(sc_q);

		is_start = valid_s1 && (func_s1 == msid_pkg::FUNC_START);
		is_req   = valid_s1 && (func_s1 == msid_pkg::FUNC_REQUEST);
		is_word  = valid_s1 && (func_s1 == msid_pkg::FUNC_WORD);

		step       = is_req && !loading_q && enc_q && sel.hit;
		load_begin = is_req && !loading_q && !step;
		req_wait   = is_req && loading_q;
		word_take  = is_word && loading_q;
		pos_inc    = {1'b0, cnt_q} + 7'd1;
		finish     = word_take && (pos_inc >= {1'b0, total});
		store      = word_take && slot.in_range;

		has_result = is_req || word_take;
		adv        = valid_s1 && (!has_result || !m_tvalid || m_tready);
		s_tready   = !valid_s1 || adv;

		tuple_o = step || finish;
		need_o  = load_begin || req_wait || (word_take && !finish);
		if (load_begin)
			owed = total;
		else if (req_wait)
			owed = (cnt_q < total) ? total - cnt_q : '0;
		else if (word_take && !finish)
			owed = total - pos_inc[PW-1:0];
		else
			owed = '0;
	end

	always_comb begin
		for (int s = 0; s < NS; s++) begin
			sum[s] = idx_q[s] + (step ? stride_q[sel.level][s] : jump_q[s]);
			if (is_start)
				idx_nx[s] = '0;
			else if ((step || (finish && enc_q)) && (sc_q > msid_pkg::CNT_W'(s)))
				idx_nx[s] = sum[s];
			else if (store && !enc_q && (slot.lane == msid_pkg::STR_W'(s)))
				idx_nx[s] = word_s1;
			else
				idx_nx[s] = idx_q[s];
		end
		for (int l = 0; l < NL; l++) begin
			if (is_start)
				rem_nx[l] = '0;
			else if (step && (sel.level == msid_pkg::LVL_W'(l)))
				rem_nx[l] = rem_q[l] - 32'd1;
			else if (step && (sel.level > msid_pkg::LVL_W'(l)))
				rem_nx[l] = saved_q[l];
			else if (store && slot.is_len && (slot.level == msid_pkg::LVL_W'(l)))
				rem_nx[l] = word_s1 - ((l == 0) ? 32'd1 : 32'd0);
			else
				rem_nx[l] = rem_q[l];
		end
	end

	always_comb begin
		data_o = '0;
		for (int s = 0; s < NS; s++) begin
			if (tuple_o && (sc_q > msid_pkg::CNT_W'(s)))
				data_o[s*32 +: 32] = idx_nx[s];
		end
		data_o[192 +: PW] = owed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			word_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NS; s++)
				idx_q[s] <= '0;
			rem_q     <= '0;
			cnt_q     <= '0;
			loading_q <= 1'b0;
		end else if (adv) begin
			for (int s = 0; s < NS; s++)
				idx_q[s] <= idx_nx[s];
			for (int l = 0; l < NL; l++)
				rem_q[l] <= rem_nx[l];
			if (is_start || load_begin || finish)
				cnt_q <= '0;
			else if (word_take)
				cnt_q <= pos_inc[PW-1:0];
			if (is_start || finish)
				loading_q <= 1'b0;
			else if (load_begin)
				loading_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (store && slot.is_jump)
				jump_q[slot.lane] <= word_s1;
			if (store && enc_q && !slot.is_jump && !slot.is_len)
				stride_q[slot.level][slot.lane] <= word_s1;
			if (finish && enc_q) begin
				for (int l = 0; l < NL; l++) begin
					if (lc_q > msid_pkg::CNT_W'(l + 1))
						saved_q[l] <= rem_q[l];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv && has_result) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			m_tdata <= data_o;
			m_tuser <= {need_o, tuple_o};
		end
	end

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] != m_tuser[1]))
		else $error("result is neither exactly a tuple nor a status");

	a_owed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[197:192] == 6'd0))
		else $error("words_needed set on a tuple");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < msid_pkg::MAX_PIECE)
		else $error("piece counter past largest piece");

	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!loading_q |-> (cnt_q == '0))
		else $error("piece counter running while not loading");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_start) |=> (!loading_q && (rem_q == '0)))
		else $error("start did not clear loading and level counts");

endmodule

[rtl/msid_level_select.sv]
module msid_level_select (
	input  msid_pkg::count_t [msid_pkg::MAX_LEVELS-1:0] remaining,
	input  logic [msid_pkg::CNT_W-1:0]                  level_count,
	output msid_pkg::level_sel_t                        sel
);

	logic [msid_pkg::MAX_LEVELS-1:0] rep;

	always_comb begin
		for (int l = 0; l < msid_pkg::MAX_LEVELS; l++) begin
			rep[l] = (level_count > msid_pkg::CNT_W'(l)) && !remaining[l][31] &&
				(remaining[l] > ((l == 0) ? 32'd0 : 32'd1));
		end
	end

	// lowest level with repeats wins
	always_comb begin
		sel = '0;
		for (int l = msid_pkg::MAX_LEVELS - 1; l >= 0; l--) begin
			if (rep[l]) begin
				sel.hit   = 1'b1;
				sel.level = msid_pkg::LVL_W'(l);
			end
		end
	end

endmodule

[rtl/msid_piece_decode.sv]
module msid_piece_decode (
	input  logic [msid_pkg::PIECE_W-1:0] pos,
	input  logic [msid_pkg::PIECE_W-1:0] total,
	input  logic [msid_pkg::CNT_W-1:0]   stream_count,
	input  logic                         encoded_mode,
	output msid_pkg::piece_slot_t        slot
);

	logic [3:0]                   group;
	logic [6:0]                   q;
	logic [msid_pkg::LVL_W-1:0]   lv;
	logic [6:0]                   base;
	logic [6:0]                   r;
	logic                         in_jump;

	// level = q / (streams + 1), found by comparing against multiples
	always_comb begin
		group   = {1'b0, stream_count} + 4'd1;
		in_jump = pos < {3'b000, stream_count};
		q       = {1'b0, pos} - {4'b0000, stream_count};
		lv      = '0;
		for (int k = 1; k < msid_pkg::MAX_LEVELS; k++) begin
			if (q >= 7'(k) * {3'b000, group})
				lv = lv + msid_pkg::LVL_W'(1);
		end
		base = 7'(lv) * {3'b000, group};
		r    = q - base;

		slot.in_range = pos < total;
		slot.is_jump  = encoded_mode && in_jump;
		slot.is_len   = encoded_mode && !in_jump && (r == {4'b0000, stream_count});
		slot.level    = lv;
		if (!encoded_mode || in_jump)
			slot.lane = pos[msid_pkg::STR_W-1:0];
		else
			slot.lane = r[msid_pkg::STR_W-1:0];
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic [5:0]       owed;
		logic             need;
		logic             tup;
		logic [5:0][31:0] idx;
	} tuple_res_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [1:0] fn;
		logic [31:0] data;
		bit         fixed;
		tuple_res_t res;
	} dir_row_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [199:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [2:0]   cfg_data;

	bit         no_idle = 1'b0;
	int         mismatch_cnt = 0;
	int         items_sent = 0;
	tuple_res_t pending_tuples[$];

	// decoder state mirror
	int          lvl_cnt;
	int          str_cnt;
	bit          enc_on;
	logic [31:0] idx_run[6];
	logic [31:0] lvl_left[6];
	logic [31:0] lvl_len[6];
	logic [31:0] lvl_stride[36];
	logic [31:0] jump[6];
	int          word_pos;
	bit          loading;

	multilevel_stride_index_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("[multilevel_stride_index_decoder] ERROR");
		$finish;
	end

	function automatic int clamp_cnt(input logic [2:0] v);
		if (v == 3'd0)
			return 1;
		if (v > 3'd6)
			return 6;
		return int'(v);
	endfunction

	function automatic int piece_words();
		return enc_on ? str_cnt + lvl_cnt * (str_cnt + 1) : str_cnt;
	endfunction

	function automatic tuple_res_t status_res(input int owed);
		tuple_res_t r;
		r = '0;
		r.need = 1'b1;
		r.owed = owed[5:0];
		return r;
	endfunction

	function automatic tuple_res_t tuple_now();
		tuple_res_t r;
		r = '0;
		r.tup = 1'b1;
		for (int s = 0; s < str_cnt; s++)
			r.idx[s] = idx_run[s];
		return r;
	endfunction

	function automatic bit decode_item(input logic [1:0] fn, input logic [31:0] w,
			output tuple_res_t res);
		int total, pos, q, lv, r;
		bit hit;
		res = '0;
		case (fn)
			msid_pkg::FUNC_START: begin
				for (int s = 0; s < 6; s++) begin
					idx_run[s] = '0;
					lvl_left[s] = '0;
				end
				word_pos = 0;
				loading = 0;
				return 0;
			end
			msid_pkg::FUNC_REQUEST: begin
				if (loading) begin
					total = piece_words();
					res = status_res(word_pos < total ? total - word_pos : 0);
					return 1;
				end
				hit = 0;
				if (enc_on) begin
					for (int l = 0; l < lvl_cnt && !hit; l++) begin
						if (!lvl_left[l][31] && lvl_left[l] > ((l > 0) ? 32'd1 : 32'd0)) begin
							hit = 1;
							for (int s = 0; s < str_cnt; s++)
								idx_run[s] = idx_run[s] + lvl_stride[l * 6 + s];
							lvl_left[l] = lvl_left[l] - 32'd1;
							for (int g = 0; g < l; g++)
								lvl_left[g] = lvl_len[g];
						end
					end
				end
				if (hit) begin
					res = tuple_now();
					return 1;
				end
				loading = 1;
				word_pos = 0;
				res = status_res(piece_words());
				return 1;
			end
			msid_pkg::FUNC_WORD: begin
				if (!loading)
					return 0;
				total = piece_words();
				pos = word_pos;
				if (pos < total) begin
					if (!enc_on) begin
						idx_run[pos] = w;
					end else if (pos < str_cnt) begin
						jump[pos] = w;
					end else begin
						q = pos - str_cnt;
						lv = q / (str_cnt + 1);
						r = q % (str_cnt + 1);
						if (r < str_cnt)
							lvl_stride[lv * 6 + r] = w;
						else
							lvl_left[lv] = w - ((lv == 0) ? 32'd1 : 32'd0);
					end
				end
				word_pos = (pos + 1) & 63;
				if (pos + 1 < total) begin
					res = status_res(total - pos - 1);
					return 1;
				end
				loading = 0;
				word_pos = 0;
				if (enc_on) begin
					for (int s = 0; s < str_cnt; s++)
						idx_run[s] = idx_run[s] + jump[s];
					for (int l = 0; l + 1 < lvl_cnt; l++)
						lvl_len[l] = lvl_left[l];
				end
				res = tuple_now();
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	function automatic dir_row_t plain_row(input logic [1:0] fn, input logic [31:0] w);
		dir_row_t row;
		row.kind = ROW_ITEM;
		row.fn = fn;
		row.data = w;
		row.fixed = 0;
		row.res = '0;
		return row;
	endfunction

	function automatic dir_row_t fixed_row(input logic [1:0] fn, input logic [31:0] w,
			input tuple_res_t res);
		dir_row_t row;
		row = plain_row(fn, w);
		row.fixed = 1;
		row.res = res;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [2:0] val);
		dir_row_t row;
		row = plain_row(idx, {29'd0, val});
		row.kind = ROW_CFG;
		return row;
	endfunction

	function automatic tuple_res_t one_index(input logic [31:0] v);
		tuple_res_t r;
		r = '0;
		r.tup = 1'b1;
		r.idx[0] = v;
		return r;
	endfunction

	task automatic send_item(input logic [1:0] fn, input logic [31:0] w, input bit use_fixed,
			input tuple_res_t fixed_res);
		tuple_res_t res;
		while (!no_idle && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (decode_item(fn, w, res))
			pending_tuples.push_back(use_fixed ? fixed_res : res);
		items_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_tuples.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			msid_pkg::CFG_LEVEL_COUNT:  lvl_cnt = clamp_cnt(val);
			msid_pkg::CFG_STREAM_COUNT: str_cnt = clamp_cnt(val);
			msid_pkg::CFG_ENCODED_MODE: enc_on = val[0];
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : check_results
		tuple_res_t want;
		m_tready <= no_idle || ($urandom_range(99) >= 27);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tuples.size() == 0) begin
				$error("result word with no expected tuple");
				mismatch_cnt++;
			end else begin
				want = pending_tuples.pop_front();
				for (int k = 0; k < 6; k++) begin
					if (m_tdata[32 * k +: 32] !== want.idx[k]) begin
						$error("index_%0d expected %h got %h", k, want.idx[k],
							m_tdata[32 * k +: 32]);
						mismatch_cnt++;
					end
				end
				if (m_tuser[0] !== want.tup) begin
					$error("tuple_valid expected %b got %b", want.tup, m_tuser[0]);
					mismatch_cnt++;
				end
				if (m_tuser[1] !== want.need) begin
					$error("need_words expected %b got %b", want.need, m_tuser[1]);
					mismatch_cnt++;
				end
				if (m_tdata[197:192] !== want.owed) begin
					$error("words_needed expected %0d got %0d", want.owed, m_tdata[197:192]);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		dir_row_t   dir_rows[$];
		logic [1:0]  fn;
		logic [31:0] w;
		int          roll;
		int          span;
		int          slot;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = msid_pkg::FUNC_START;
		cfg_we = 1'b0;
		cfg_index = msid_pkg::CFG_LEVEL_COUNT;
		cfg_data = '0;

		lvl_cnt = 1;
		str_cnt = 1;
		enc_on = 1;
		for (int i = 0; i < 6; i++) begin
			idx_run[i] = '0;
			lvl_left[i] = '0;
			lvl_len[i] = '0;
			jump[i] = '0;
		end
		for (int i = 0; i < 36; i++)
			lvl_stride[i] = '0;
		word_pos = 0;
		loading = 0;

		// one level, one stream after reset
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_REQUEST, 32'd0, status_res(3)));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_REQUEST, 32'd0, status_res(3)));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_WORD, 32'h7FFF_FFFF, status_res(2)));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_WORD, 32'h8000_0000, status_res(1)));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_WORD, 32'd2, one_index(32'h7FFF_FFFF)));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_REQUEST, 32'd0, one_index(32'hFFFF_FFFF)));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_REQUEST, 32'd0, status_res(3)));
		dir_rows.push_back(plain_row(FUNC_NONE, 32'hFFFF_FFFF));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_START, 32'd0));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'd5));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_REQUEST, 32'd0, status_res(3)));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_WORD, 32'hFFFF_FFFF, status_res(2)));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_WORD, 32'd1, status_res(1)));
		// zero length at level 0 wraps and leaves no repeats
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_WORD, 32'd0, one_index(32'hFFFF_FFFF)));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_REQUEST, 32'd0, status_res(3)));
		// level count lowered in the middle of a piece
		dir_rows.push_back(cfg_row(msid_pkg::CFG_LEVEL_COUNT, 3'd2));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_START, 32'd0));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_REQUEST, 32'd0, status_res(5)));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'd3));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'd4));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'd2));
		dir_rows.push_back(cfg_row(msid_pkg::CFG_LEVEL_COUNT, 3'd0));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'd9));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_REQUEST, 32'd0));
		// raw mode, stream count clamped to six
		dir_rows.push_back(cfg_row(msid_pkg::CFG_ENCODED_MODE, 3'b110));
		dir_rows.push_back(cfg_row(msid_pkg::CFG_STREAM_COUNT, 3'd7));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_START, 32'd0));
		dir_rows.push_back(fixed_row(msid_pkg::FUNC_REQUEST, 32'd0, status_res(6)));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'h8000_0000));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'h7FFF_FFFF));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'd0));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'hFFFF_FFFF));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'd1));
		dir_rows.push_back(plain_row(msid_pkg::FUNC_WORD, 32'h5555_5555));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_reg(dir_rows[i].fn, dir_rows[i].data[2:0]);
			end else begin
				send_item(dir_rows[i].fn, dir_rows[i].data, dir_rows[i].fixed, dir_rows[i].res);
			end
		end

		items_sent = 0;
		while (items_sent < 1050) begin
			no_idle = (items_sent >= 400 && items_sent < 600);
			drain_results();
			roll = $urandom_range(99);
			write_reg(msid_pkg::CFG_LEVEL_COUNT, roll < 30 ? 3'($urandom_range(1, 2)) :
				roll < 45 ? 3'd6 : 3'($urandom_range(0, 7)));
			roll = $urandom_range(99);
			write_reg(msid_pkg::CFG_STREAM_COUNT, roll < 30 ? 3'($urandom_range(1, 2)) :
				roll < 45 ? 3'd6 : 3'($urandom_range(0, 7)));
			write_reg(msid_pkg::CFG_ENCODED_MODE,
				{2'($urandom_range(3)), 1'($urandom_range(99) < 80)});
			send_item(msid_pkg::FUNC_START, $urandom, 0, '0);
			span = $urandom_range(20, 120);
			repeat (span) begin
				roll = $urandom_range(99);
				if (loading)
					fn = roll < 90 ? msid_pkg::FUNC_WORD : roll < 93 ? msid_pkg::FUNC_REQUEST :
						roll < 95 ? msid_pkg::FUNC_START : roll < 97 ? FUNC_NONE :
						msid_pkg::FUNC_WORD;
				else
					fn = roll < 82 ? msid_pkg::FUNC_REQUEST : roll < 87 ? msid_pkg::FUNC_WORD :
						roll < 91 ? FUNC_NONE : roll < 94 ? msid_pkg::FUNC_START :
						msid_pkg::FUNC_REQUEST;
				w = $urandom;
				slot = word_pos - str_cnt;
				if (fn == msid_pkg::FUNC_WORD && loading && enc_on && slot >= 0 &&
						slot % (str_cnt + 1) == str_cnt) begin
					roll = $urandom_range(99);
					w = roll < 85 ? 32'($urandom_range(0, 3)) :
						roll < 95 ? 32'($urandom_range(0, 12)) : 32'($urandom);
				end else if ($urandom_range(99) < 30) begin
					w = 32'($signed($urandom_range(0, 16)) - 8);
				end
				send_item(fn, w, 0, '0);
				if ($urandom_range(99) < 2)
					drain_results();
			end
		end

		no_idle = 0;
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("[multilevel_stride_index_decoder] OK");
		else
			$display("[multilevel_stride_index_decoder] ERROR");
		$finish;
	end

endmodule
